>>> sv/jbr_pkg.sv
// shared constants, types and crc function of the controller responder
`default_nettype none
package jbr_pkg;

   localparam int PAK_BLOCK_BYTES = 32;
   localparam int GAME_ID_BYTES   = 10;
   localparam int IDX_W           = 6;
   localparam int CSR_ADDR_W      = 4;

   localparam logic [7:0]  CRC_POLY      = 8'h85;
   localparam logic [15:0] ADDR_MASK     = 16'hFFE0;
   localparam logic [7:0]  ID_FILL       = 8'h80;
   localparam logic [7:0]  PAK_CHANGED   = 8'h02;

   localparam logic [7:0]  CMD_PROBE     = 8'h00;
   localparam logic [7:0]  CMD_POLL      = 8'h01;
   localparam logic [7:0]  CMD_READ      = 8'h02;
   localparam logic [7:0]  CMD_WRITE     = 8'h03;
   localparam logic [7:0]  CMD_GAME_ID   = 8'h1D;
   localparam logic [7:0]  CMD_RESET     = 8'hFF;

   localparam logic [1:0]  REG_DEVICE_TYPE    = 2'd0;
   localparam logic [1:0]  REG_PRESENT_STATUS = 2'd1;
   localparam logic [1:0]  REG_RUMBLE_ADDRESS = 2'd2;

   localparam logic [15:0] DEVICE_TYPE_RESET    = 16'h0500;
   localparam logic [7:0]  PRESENT_STATUS_RESET = 8'h01;
   localparam logic [15:0] RUMBLE_ADDRESS_RESET = 16'hC000;

   typedef enum logic [1:0] {
      JOB_BYTES,
      JOB_READ,
      JOB_CRC
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   len_m1;
      logic [31:0]  word;
      logic         rumble;
   } job_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
      logic       rumble_on;
   } rsp_type;

   typedef struct packed {
      logic [15:0] device_type;
      logic [7:0]  present_status;
      logic [15:0] rumble_address;
   } cfg_type;

   function automatic logic [7:0] crc_shift_byte(input logic [7:0] crc,
                                                 input logic [7:0] b);
      logic [7:0] c;
      logic [7:0] tap;
      c = crc;
      for (int j = 7; j >= 0; j--) begin
         tap = c[7] ? CRC_POLY : 8'h00;
         c   = {c[6:0], b[j]} ^ tap;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> sv/jbr_front.sv
// frame decoder: takes received bytes and timeouts, issues reply jobs
`default_nettype none
module jbr_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic            func,
   input  wire logic [7:0]      rx_byte,
   input  wire logic [31:0]     report_word,
   input  wire jbr_pkg::cfg_type cfg,
   output logic                 job_push,
   output jbr_pkg::job_type     job
);
   import jbr_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_READ,
      PH_WRITE,
      PH_GAME_ID,
      PH_DISCARD
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [15:0]      addr_ff, addr_in;
   logic [7:0]       crc_ff, crc_in;
   logic             nonzero_ff, nonzero_in;
   logic             shown_ff, shown_in;
   logic             rumble_ff, rumble_in;

   logic [7:0]  crc_step;
   logic        nonzero_step;
   logic [15:0] rd_addr;
   logic        rd_hit;
   logic        wr_hit;
   logic        rumble_step;

   assign crc_step     = crc_shift_byte(crc_ff, rx_byte);
   assign nonzero_step = nonzero_ff | (rx_byte != 8'h00);
   assign rd_addr      = {addr_ff[7:0], rx_byte};
   assign rd_hit       = (rd_addr & ADDR_MASK) == cfg.rumble_address;
   assign wr_hit       = (addr_ff & ADDR_MASK) == cfg.rumble_address;
   assign rumble_step  = wr_hit ? nonzero_step : rumble_ff;

   always_comb begin
      phase_in   = phase_ff;
      index_in   = index_ff;
      addr_in    = addr_ff;
      crc_in     = crc_ff;
      nonzero_in = nonzero_ff;
      shown_in   = shown_ff;
      rumble_in  = rumble_ff;
      job_push   = 1'b0;
      job.kind   = JOB_BYTES;
      job.len_m1 = 2'd0;
      job.word   = report_word;
      job.rumble = rumble_ff;
      if (accept) begin
         if (func) begin
            phase_in = PH_IDLE;
            index_in = '0;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  index_in = '0;
                  unique case (rx_byte)
                     CMD_RESET: begin
                        job_push   = 1'b1;
                        job.len_m1 = 2'd2;
                        job.word   = {cfg.device_type,
                                      shown_ff ? (cfg.present_status | PAK_CHANGED) : 8'h00,
                                      8'h00};
                        shown_in   = 1'b0;
                     end
                     CMD_PROBE: begin
                        job_push   = 1'b1;
                        job.len_m1 = 2'd2;
                        job.word   = {cfg.device_type,
                                      shown_ff ? cfg.present_status : 8'h00, 8'h00};
                     end
                     CMD_POLL: begin
                        job_push   = 1'b1;
                        job.len_m1 = 2'd3;
                        job.word   = report_word;
                        shown_in   = 1'b1;
                     end
                     CMD_READ: begin
                        phase_in = PH_READ;
                        addr_in  = '0;
                     end
                     CMD_WRITE: begin
                        phase_in   = PH_WRITE;
                        addr_in    = '0;
                        crc_in     = '0;
                        nonzero_in = 1'b0;
                     end
                     CMD_GAME_ID: phase_in = PH_GAME_ID;
                     default:     phase_in = PH_DISCARD;
                  endcase
               end
               PH_READ: begin
                  addr_in  = rd_addr;
                  index_in = index_ff + IDX_W'(1);
                  if (index_ff != '0) begin
                     job_push = 1'b1;
                     job.kind = JOB_READ;
                     job.word = {rd_hit ? 8'h00 : ID_FILL, 24'h000000};
                     phase_in = PH_IDLE;
                     index_in = '0;
                  end
               end
               PH_WRITE: begin
                  index_in = index_ff + IDX_W'(1);
                  if (index_ff < IDX_W'(2)) begin
                     addr_in = {addr_ff[7:0], rx_byte};
                  end else begin
                     crc_in     = crc_step;
                     nonzero_in = nonzero_step;
                     if (index_ff == IDX_W'(PAK_BLOCK_BYTES + 1)) begin
                        rumble_in  = rumble_step;
                        job_push   = 1'b1;
                        job.kind   = JOB_CRC;
                        job.word   = {crc_step, 24'h000000};
                        job.rumble = rumble_step;
                        phase_in   = PH_IDLE;
                        index_in   = '0;
                     end
                  end
               end
               PH_GAME_ID: begin
                  index_in = index_ff + IDX_W'(1);
                  if (index_ff >= IDX_W'(GAME_ID_BYTES - 1)) begin
                     phase_in = PH_IDLE;
                     index_in = '0;
                  end
               end
               PH_DISCARD: phase_in = PH_DISCARD;
               default: begin
                  phase_in = PH_IDLE;
                  index_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         index_ff   <= '0;
         addr_ff    <= '0;
         crc_ff     <= '0;
         nonzero_ff <= 1'b0;
         shown_ff   <= 1'b0;
         rumble_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         addr_ff    <= addr_in;
         crc_ff     <= crc_in;
         nonzero_ff <= nonzero_in;
         shown_ff   <= shown_in;
         rumble_ff  <= rumble_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/jbr_job_queue.sv
// two-entry queue of reply jobs between decoder and reply generator
`default_nettype none
module jbr_job_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire jbr_pkg::job_type push_job,
   output logic                  full,
   output logic                  empty,
   input  wire logic             pop,
   output jbr_pkg::job_type      head_job
);
   import jbr_pkg::*;

   job_type    ent_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = ent_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? ~wr_ff : wr_ff;
      rd_in    = do_pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

>>> sv/jbr_back.sv
// reply generator: expands jobs into reply bytes and holds the result queue
`default_nettype none
module jbr_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire jbr_pkg::job_type job,
   output logic                  job_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output jbr_pkg::rsp_type      rsp
);
   import jbr_pkg::*;

   logic             busy_ff, busy_in;
   job_kind_type     kind_ff, kind_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      word_ff, word_in;
   logic [7:0]       crc_ff, crc_in;
   logic             rumble_ff, rumble_in;

   rsp_type    ent_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   logic       out_full;
   logic       emit;
   logic       emit_last;
   logic [7:0] emit_byte;
   logic       out_pop;

   assign out_full = count_ff == 2'd2;
   assign emit     = busy_ff && !out_full;
   assign out_pop  = rsp_pop && (count_ff != 2'd0);
   assign job_pop  = job_valid && (!busy_ff || (emit && emit_last));

   always_comb begin
      case (kind_ff)
         JOB_BYTES: begin
            emit_byte = word_ff[31:24];
            emit_last = cnt_ff == '0;
         end
         JOB_READ: begin
            if (cnt_ff == IDX_W'(PAK_BLOCK_BYTES)) begin
               emit_byte = crc_shift_byte(crc_ff, 8'h00);
               emit_last = 1'b1;
            end else begin
               emit_byte = word_ff[31:24];
               emit_last = 1'b0;
            end
         end
         JOB_CRC: begin
            emit_byte = crc_shift_byte(word_ff[31:24], 8'h00);
            emit_last = 1'b1;
         end
         default: begin
            emit_byte = word_ff[31:24];
            emit_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      busy_in   = busy_ff;
      kind_in   = kind_ff;
      cnt_in    = cnt_ff;
      word_in   = word_ff;
      crc_in    = crc_ff;
      rumble_in = rumble_ff;
      if (job_pop) begin
         busy_in   = 1'b1;
         kind_in   = job.kind;
         cnt_in    = (job.kind == JOB_BYTES) ? IDX_W'(job.len_m1) : '0;
         word_in   = job.word;
         crc_in    = 8'h00;
         rumble_in = job.rumble;
      end else if (emit) begin
         if (emit_last) begin
            busy_in = 1'b0;
         end else if (kind_ff == JOB_READ) begin
            cnt_in = cnt_ff + IDX_W'(1);
            crc_in = crc_shift_byte(crc_ff, word_ff[31:24]);
         end else begin
            cnt_in  = cnt_ff - IDX_W'(1);
            word_in = {word_ff[23:0], 8'h00};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         kind_ff  <= JOB_BYTES;
         cnt_ff   <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         kind_ff  <= kind_in;
         cnt_ff   <= cnt_in;
         wr_ff    <= emit ? ~wr_ff : wr_ff;
         rd_ff    <= out_pop ? ~rd_ff : rd_ff;
         count_ff <= count_ff + {1'b0, emit} - {1'b0, out_pop};
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      crc_ff    <= crc_in;
      rumble_ff <= rumble_in;
      if (emit) begin
         ent_ff[wr_ff] <= '{tx_byte: emit_byte, last_byte: emit_last, rumble_on: rumble_ff};
      end
   end

   assign rsp_empty = count_ff == 2'd0;
   assign rsp       = ent_ff[rd_ff];

endmodule
`default_nettype wire

>>> sv/joybus_controller_responder.sv
// top level of the controller responder: register port, decoder, job queue, reply generator
//
//   channel   direction  handshake              payload
//   req       in         req_push / req_full    func, rx_byte, report_word
//   rsp       out        rsp_pop / rsp_empty    tx_byte, last_byte, rumble_on
//   csr       in/out     psel, penable, pready  paddr, pwdata, prdata
//
// one item is decoded per cycle unless the job queue is full; a reply leaves at one byte
// per cycle from the generator while the result queue has room; a read reply is 33 bytes,
// status 3, report 4, write crc 1; a two-entry job queue lets the decoder keep taking items
// while a long reply drains; reset clears all frame state and both queues
`default_nettype none
module joybus_controller_responder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          req_func,
   input  wire logic [7:0]                    req_rx_byte,
   input  wire logic [31:0]                   req_report_word,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [7:0]                         rsp_tx_byte,
   output logic                               rsp_last_byte,
   output logic                               rsp_rumble_on,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [jbr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import jbr_pkg::*;

   cfg_type    cfg_ff;
   logic [1:0] reg_index;
   logic       csr_write;
   logic       accept;
   logic       job_push;
   job_type    job_in_q;
   job_type    job_head;
   logic       job_empty;
   logic       job_pop;
   rsp_type    rsp;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_type    <= DEVICE_TYPE_RESET;
         cfg_ff.present_status <= PRESENT_STATUS_RESET;
         cfg_ff.rumble_address <= RUMBLE_ADDRESS_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_DEVICE_TYPE:    cfg_ff.device_type    <= csr_pwdata[15:0];
            REG_PRESENT_STATUS: cfg_ff.present_status <= csr_pwdata[7:0];
            REG_RUMBLE_ADDRESS: cfg_ff.rumble_address <= csr_pwdata[15:0];
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DEVICE_TYPE:    csr_prdata = {16'h0000, cfg_ff.device_type};
         REG_PRESENT_STATUS: csr_prdata = {24'h000000, cfg_ff.present_status};
         REG_RUMBLE_ADDRESS: csr_prdata = {16'h0000, cfg_ff.rumble_address};
         default:            csr_prdata = 32'h00000000;
      endcase
   end

   assign accept = req_push && !req_full;

   jbr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_func),
      .rx_byte     (req_rx_byte),
      .report_word (req_report_word),
      .cfg         (cfg_ff),
      .job_push    (job_push),
      .job         (job_in_q)
   );

   jbr_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in_q),
      .full     (req_full),
      .empty    (job_empty),
      .pop      (job_pop),
      .head_job (job_head)
   );

   jbr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!job_empty),
      .job       (job_head),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_tx_byte   = rsp.tx_byte;
   assign rsp_last_byte = rsp.last_byte;
   assign rsp_rumble_on = rsp.rumble_on;

endmodule
`default_nettype wire

>>> sv/jbr_checker.sv
// port checker for the controller responder and its bind
`default_nettype none
module jbr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic        rsp_last_byte,
   input wire logic        rsp_rumble_on,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pready
);

   // the result queue comes out of reset empty and the job queue not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a waiting result holds until it is transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_tx_byte)
                                 && $stable(rsp_last_byte) && $stable(rsp_rumble_on))
      else $error("result changed while waiting");

   // rumble state cannot change inside one reply
   a_rumble_in_reply: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_last_byte |=>
         rsp_empty || (rsp_rumble_on == $past(rsp_rumble_on)))
      else $error("rumble changed within a reply");

   // the register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel && !csr_penable |=> csr_pready)
      else $error("register access stalled");

endmodule

bind joybus_controller_responder jbr_checker u_checker (.*);
`default_nettype wire

>>> tb/jbr_reply_checker.sv
// reply checker of the responder: watches all ports but prdata, predicts replies and compares
module jbr_reply_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   input  wire logic                           req_full,
   input  wire logic                           req_func,
   input  wire logic [7:0]                     req_rx_byte,
   input  wire logic [31:0]                    req_report_word,
   input  wire logic                           rsp_empty,
   input  wire logic                           rsp_pop,
   input  wire logic [7:0]                     rsp_tx_byte,
   input  wire logic                           rsp_last_byte,
   input  wire logic                           rsp_rumble_on,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic                           csr_pready,
   input  wire logic [jbr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  checked_count
);

   typedef enum logic [2:0] {
      FRAME_IDLE,
      FRAME_READ,
      FRAME_WRITE,
      FRAME_GAME_ID,
      FRAME_DISCARD
   } frame_state_type;

   jbr_pkg::cfg_type  cfg;
   frame_state_type   frame_state;
   logic [5:0]        byte_count;
   logic [15:0]       pak_addr;
   logic [7:0]        write_crc;
   logic              write_nonzero;
   logic              pak_visible;
   logic              motor_on;
   jbr_pkg::rsp_type  reply_q[$];

   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = acc[7];
         acc = {acc[6:0], data[i]};
         if (fb) acc = acc ^ jbr_pkg::CRC_POLY;
      end
      return acc;
   endfunction

   task automatic queue_reply(input logic [7:0] b, input logic last);
      jbr_pkg::rsp_type r;
      r.tx_byte   = b;
      r.last_byte = last;
      r.rumble_on = motor_on;
      reply_q.push_back(r);
   endtask

   task automatic predict_reply(input logic func, input logic [7:0] b, input logic [31:0] w);
      logic [7:0] st;
      logic [7:0] fill;
      logic [7:0] crc;
      if (func) begin
         frame_state = FRAME_IDLE;
         byte_count  = 0;
      end else begin
         case (frame_state)
            FRAME_IDLE: begin
               byte_count = 0;
               if (b == jbr_pkg::CMD_RESET || b == jbr_pkg::CMD_PROBE) begin
                  if (!pak_visible) st = 8'h00;
                  else if (b == jbr_pkg::CMD_RESET)
                     st = cfg.present_status | jbr_pkg::PAK_CHANGED;
                  else st = cfg.present_status;
                  if (b == jbr_pkg::CMD_RESET) pak_visible = 1'b0;
                  queue_reply(cfg.device_type[15:8], 1'b0);
                  queue_reply(cfg.device_type[7:0], 1'b0);
                  queue_reply(st, 1'b1);
               end else if (b == jbr_pkg::CMD_POLL) begin
                  pak_visible = 1'b1;
                  for (int k = 0; k < 4; k++) queue_reply(w[31-8*k -: 8], k == 3);
               end else if (b == jbr_pkg::CMD_READ) begin
                  frame_state = FRAME_READ;
                  pak_addr    = 16'h0000;
               end else if (b == jbr_pkg::CMD_WRITE) begin
                  frame_state   = FRAME_WRITE;
                  pak_addr      = 16'h0000;
                  write_crc     = 8'h00;
                  write_nonzero = 1'b0;
               end else if (b == jbr_pkg::CMD_GAME_ID) begin
                  frame_state = FRAME_GAME_ID;
               end else begin
                  frame_state = FRAME_DISCARD;
               end
            end
            FRAME_READ: begin
               pak_addr   = {pak_addr[7:0], b};
               byte_count = byte_count + 1;
               if (byte_count == 2) begin
                  fill = ((pak_addr & jbr_pkg::ADDR_MASK) == cfg.rumble_address) ?
                         8'h00 : jbr_pkg::ID_FILL;
                  crc = 8'h00;
                  for (int k = 0; k < jbr_pkg::PAK_BLOCK_BYTES; k++) begin
                     crc = crc8_step(crc, fill);
                     queue_reply(fill, 1'b0);
                  end
                  crc = crc8_step(crc, 8'h00);
                  queue_reply(crc, 1'b1);
                  frame_state = FRAME_IDLE;
                  byte_count  = 0;
               end
            end
            FRAME_WRITE: begin
               if (byte_count < 2) begin
                  pak_addr   = {pak_addr[7:0], b};
                  byte_count = byte_count + 1;
               end else begin
                  write_crc = crc8_step(write_crc, b);
                  if (b != 8'h00) write_nonzero = 1'b1;
                  byte_count = byte_count + 1;
                  if (byte_count == 2 + jbr_pkg::PAK_BLOCK_BYTES) begin
                     write_crc = crc8_step(write_crc, 8'h00);
                     if ((pak_addr & jbr_pkg::ADDR_MASK) == cfg.rumble_address)
                        motor_on = write_nonzero;
                     queue_reply(write_crc, 1'b1);
                     frame_state = FRAME_IDLE;
                     byte_count  = 0;
                  end
               end
            end
            FRAME_GAME_ID: begin
               byte_count = byte_count + 1;
               if (byte_count >= jbr_pkg::GAME_ID_BYTES) begin
                  frame_state = FRAME_IDLE;
                  byte_count  = 0;
               end
            end
            FRAME_DISCARD: ;
            default: begin
               frame_state = FRAME_IDLE;
               byte_count  = 0;
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : monitor
      jbr_pkg::rsp_type exp_rsp;
      if (reset) begin
         cfg.device_type    = jbr_pkg::DEVICE_TYPE_RESET;
         cfg.present_status = jbr_pkg::PRESENT_STATUS_RESET;
         cfg.rumble_address = jbr_pkg::RUMBLE_ADDRESS_RESET;
         frame_state   = FRAME_IDLE;
         byte_count    = 0;
         pak_addr      = 16'h0000;
         write_crc     = 8'h00;
         write_nonzero = 1'b0;
         pak_visible   = 1'b0;
         motor_on      = 1'b0;
         reply_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (reply_q.size() == 0) begin
               $error("result transfer with no reply waiting: tx_byte %h", rsp_tx_byte);
               fail_count++;
            end else begin
               exp_rsp = reply_q.pop_front();
               checked_count++;
               if (rsp_tx_byte !== exp_rsp.tx_byte) begin
                  $error("tx_byte: expected %h, actual %h", exp_rsp.tx_byte, rsp_tx_byte);
                  fail_count++;
               end
               if (rsp_last_byte !== exp_rsp.last_byte) begin
                  $error("last_byte: expected %b, actual %b", exp_rsp.last_byte,
                         rsp_last_byte);
                  fail_count++;
               end
               if (rsp_rumble_on !== exp_rsp.rumble_on) begin
                  $error("rumble_on: expected %b, actual %b", exp_rsp.rumble_on,
                         rsp_rumble_on);
                  fail_count++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[jbr_pkg::CSR_ADDR_W-1:2])
               jbr_pkg::REG_DEVICE_TYPE:    cfg.device_type    = csr_pwdata[15:0];
               jbr_pkg::REG_PRESENT_STATUS: cfg.present_status = csr_pwdata[7:0];
               jbr_pkg::REG_RUMBLE_ADDRESS: cfg.rumble_address = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) predict_reply(req_func, req_rx_byte, req_report_word);
      end
      pending_count = reply_q.size();
   end

endmodule

>>> tb/tb_joybus_controller_responder.sv
// testbench top of the controller responder: clock, reset, stimulus and verdict
module tb_joybus_controller_responder;

   typedef enum int {
      FK_PROBE,
      FK_RESET,
      FK_POLL,
      FK_READ,
      FK_WRITE,
      FK_GAME_ID,
      FK_UNKNOWN,
      FK_BROKEN_READ,
      FK_BROKEN_WRITE,
      FK_BROKEN_GAME_ID,
      FK_IDLE_TIMEOUT
   } frame_kind_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_func;
   logic [7:0]  req_rx_byte;
   logic [31:0] req_report_word;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last_byte;
   logic        rsp_rumble_on;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [jbr_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          fail_count;
   int          pending_count;
   int          checked_count;
   int          items_sent;
   int          burst_left;
   int          settings_used;
   bit          no_gaps;
   logic [15:0] rumble_addr_set;

   joybus_controller_responder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_rx_byte     (req_rx_byte),
      .req_report_word (req_report_word),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_rumble_on   (rsp_rumble_on),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   jbr_reply_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_rx_byte     (req_rx_byte),
      .req_report_word (req_report_word),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_rumble_on   (rsp_rumble_on),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("timeout with %0d replies outstanding", pending_count);
      $display("RESULT: ERROR");
      $finish;
   end

   // one input transfer, in bursts with random gaps before each burst unless no_gaps is set
   task automatic push_item(input logic func, input logic [7:0] b, input logic [31:0] w,
                            input bit counts);
      int gap;
      if (burst_left == 0) begin
         gap        = no_gaps ? 0 : $urandom_range(0, 8);
         burst_left = $urandom_range(1, 16);
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_push        = 1'b1;
      req_func        = func;
      req_rx_byte     = b;
      req_report_word = w;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      req_push = 1'b0;
      if (counts) items_sent++;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // registers change only once every reply has drained and the decoder has settled
   task automatic apply_setting(input logic [15:0] dev, input logic [7:0] st,
                                input logic [15:0] rum);
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_write(jbr_pkg::REG_DEVICE_TYPE, {16'($urandom()), dev});
      csr_write(jbr_pkg::REG_PRESENT_STATUS, {24'($urandom()), st});
      csr_write(jbr_pkg::REG_RUMBLE_ADDRESS, {16'($urandom()), rum});
      rumble_addr_set = rum;
      settings_used++;
   endtask

   function automatic logic [15:0] pick_address();
      if ($urandom_range(0, 1)) return rumble_addr_set | 16'($urandom_range(0, 31));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic send_frame(input frame_kind_type kind);
      logic [15:0] addr;
      logic [7:0]  cmd;
      int          n;
      int          pos;
      int          fill_mode;
      addr = pick_address();
      case (kind)
         FK_PROBE: push_item(1'b0, jbr_pkg::CMD_PROBE, $urandom(), 1'b1);
         FK_RESET: push_item(1'b0, jbr_pkg::CMD_RESET, $urandom(), 1'b1);
         FK_POLL:  push_item(1'b0, jbr_pkg::CMD_POLL, $urandom(), 1'b1);
         FK_READ: begin
            push_item(1'b0, jbr_pkg::CMD_READ, $urandom(), 1'b1);
            push_item(1'b0, addr[15:8], $urandom(), 1'b1);
            push_item(1'b0, addr[7:0], $urandom(), 1'b1);
         end
         FK_WRITE: begin
            fill_mode = $urandom_range(0, 2);
            pos       = $urandom_range(0, jbr_pkg::PAK_BLOCK_BYTES - 1);
            push_item(1'b0, jbr_pkg::CMD_WRITE, $urandom(), 1'b1);
            push_item(1'b0, addr[15:8], $urandom(), 1'b1);
            push_item(1'b0, addr[7:0], $urandom(), 1'b1);
            for (int i = 0; i < jbr_pkg::PAK_BLOCK_BYTES; i++) begin
               if (fill_mode == 0) cmd = 8'h00;
               else if (fill_mode == 1) cmd = (i == pos) ? 8'($urandom_range(1, 255)) : 8'h00;
               else cmd = 8'($urandom_range(0, 255));
               push_item(1'b0, cmd, $urandom(), 1'b1);
            end
         end
         FK_GAME_ID: begin
            push_item(1'b0, jbr_pkg::CMD_GAME_ID, $urandom(), 1'b1);
            repeat (jbr_pkg::GAME_ID_BYTES)
               push_item(1'b0, 8'($urandom_range(0, 255)), $urandom(), 1'b1);
         end
         FK_UNKNOWN: begin
            do cmd = 8'($urandom_range(0, 255));
            while (cmd == jbr_pkg::CMD_PROBE || cmd == jbr_pkg::CMD_POLL ||
                   cmd == jbr_pkg::CMD_READ || cmd == jbr_pkg::CMD_WRITE ||
                   cmd == jbr_pkg::CMD_GAME_ID || cmd == jbr_pkg::CMD_RESET);
            push_item(1'b0, cmd, $urandom(), 1'b1);
            repeat ($urandom_range(0, 4))
               push_item(1'b0, 8'($urandom_range(0, 255)), $urandom(), 1'b0);
            push_item(1'b1, 8'($urandom_range(0, 255)), $urandom(), 1'b0);
         end
         FK_BROKEN_READ: begin
            push_item(1'b0, jbr_pkg::CMD_READ, $urandom(), 1'b1);
            if ($urandom_range(0, 1)) push_item(1'b0, addr[15:8], $urandom(), 1'b1);
            push_item(1'b1, 8'($urandom_range(0, 255)), $urandom(), 1'b1);
         end
         FK_BROKEN_WRITE: begin
            n = $urandom_range(0, jbr_pkg::PAK_BLOCK_BYTES + 1);
            push_item(1'b0, jbr_pkg::CMD_WRITE, $urandom(), 1'b1);
            repeat (n) push_item(1'b0, 8'($urandom_range(0, 255)), $urandom(), 1'b1);
            push_item(1'b1, 8'($urandom_range(0, 255)), $urandom(), 1'b1);
         end
         FK_BROKEN_GAME_ID: begin
            push_item(1'b0, jbr_pkg::CMD_GAME_ID, $urandom(), 1'b1);
            repeat ($urandom_range(0, jbr_pkg::GAME_ID_BYTES - 1))
               push_item(1'b0, 8'($urandom_range(0, 255)), $urandom(), 1'b1);
            push_item(1'b1, 8'($urandom_range(0, 255)), $urandom(), 1'b1);
         end
         default: push_item(1'b1, 8'($urandom_range(0, 255)), $urandom(), 1'b0);
      endcase
   endtask

   // mostly well-formed frames, with aborted frames, unknown commands and stray timeouts
   task automatic run_random(input int n);
      int target;
      target = items_sent + n;
      send_frame(FK_WRITE);
      while (items_sent < target) begin
         case ($urandom_range(0, 15))
            0, 1:    send_frame(FK_PROBE);
            2:       send_frame(FK_RESET);
            3, 4:    send_frame(FK_POLL);
            5, 6, 7: send_frame(FK_READ);
            8, 9:    send_frame(FK_WRITE);
            10:      send_frame(FK_GAME_ID);
            11:      send_frame(FK_UNKNOWN);
            12:      send_frame(FK_BROKEN_READ);
            13:      send_frame(FK_BROKEN_WRITE);
            14:      send_frame(FK_BROKEN_GAME_ID);
            default: send_frame(FK_IDLE_TIMEOUT);
         endcase
      end
   endtask

   // result side stalls on its own pattern, switching between no, short and long stalls
   initial begin : receiver
      int stall_left;
      int cycle_count;
      int stall_mode;
      stall_left  = 0;
      cycle_count = 0;
      stall_mode  = 1;
      rsp_pop     = 1'b0;
      forever begin
         @(negedge clock);
         cycle_count++;
         if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 2);
         if (stall_left > 0) begin
            rsp_pop = 1'b0;
            stall_left--;
         end else begin
            rsp_pop = 1'b1;
            if (stall_mode == 1 && $urandom_range(0, 1)) stall_left = $urandom_range(1, 3);
            else if (stall_mode == 2 && $urandom_range(0, 7) == 0)
               stall_left = $urandom_range(4, 20);
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_push        = 1'b0;
      req_func        = 1'b0;
      req_rx_byte     = 8'h00;
      req_report_word = 32'h0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = 32'h0;
      items_sent      = 0;
      burst_left      = 0;
      settings_used   = 1;
      no_gaps         = 1'b0;
      rumble_addr_set = jbr_pkg::RUMBLE_ADDRESS_RESET;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // status with pak hidden, shown after poll, hidden again by reset
      push_item(1'b1, 8'hA5, 32'h0, 1'b0);
      push_item(1'b0, jbr_pkg::CMD_PROBE, 32'h0, 1'b1);
      push_item(1'b0, jbr_pkg::CMD_RESET, 32'h0, 1'b1);
      push_item(1'b0, jbr_pkg::CMD_POLL, 32'hFFFF_FFFF, 1'b1);
      push_item(1'b0, jbr_pkg::CMD_POLL, 32'h0000_0000, 1'b1);
      push_item(1'b0, jbr_pkg::CMD_PROBE, 32'h0, 1'b1);
      push_item(1'b0, jbr_pkg::CMD_RESET, 32'h0, 1'b1);
      push_item(1'b0, jbr_pkg::CMD_PROBE, 32'h0, 1'b1);
      push_item(1'b0, jbr_pkg::CMD_POLL, 32'h1234_5678, 1'b1);
      // read of the rumble block with low bits set, then of the top address
      push_item(1'b0, jbr_pkg::CMD_READ, 32'h0, 1'b1);
      push_item(1'b0, 8'hC0, 32'h0, 1'b1);
      push_item(1'b0, 8'h1F, 32'h0, 1'b1);
      push_item(1'b0, jbr_pkg::CMD_READ, 32'h0, 1'b1);
      push_item(1'b0, 8'hFF, 32'h0, 1'b1);
      push_item(1'b0, 8'hFF, 32'h0, 1'b1);
      // partial read dropped by a timeout
      push_item(1'b0, jbr_pkg::CMD_READ, 32'h0, 1'b1);
      push_item(1'b0, 8'hC0, 32'h0, 1'b1);
      push_item(1'b1, 8'h00, 32'h0, 1'b1);
      // unknown command swallows bytes until a timeout
      push_item(1'b0, 8'h55, 32'h0, 1'b1);
      push_item(1'b0, jbr_pkg::CMD_POLL, 32'h0, 1'b0);
      push_item(1'b1, 8'hFF, 32'h0, 1'b0);
      // game id cut short
      push_item(1'b0, jbr_pkg::CMD_GAME_ID, 32'h0, 1'b1);
      push_item(1'b0, jbr_pkg::CMD_PROBE, 32'h0, 1'b1);
      push_item(1'b1, 8'h00, 32'h0, 1'b1);

      apply_setting(16'hFFFF, 8'hFF, 16'h0000);
      no_gaps = 1'b1;
      run_random(50);
      apply_setting(16'h0000, 8'h00, 16'hFFE0);
      no_gaps = 1'b0;
      run_random(50);
      apply_setting(16'($urandom()), 8'($urandom()),
                    $urandom_range(0, 1) ? (16'($urandom()) & jbr_pkg::ADDR_MASK)
                                         : 16'($urandom()));
      run_random(55);

      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("covered %0d input transfers under %0d register settings", items_sent,
               settings_used);
      $display("checked %0d result transfers, %0d failures", checked_count, fail_count);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
